FILE: src/rspt_pkg.sv
// ----------------------------------------------------------------------------
// rspt_pkg: route segment progress tracker shared definitions
// Widths, function codes, register map and controller states.
// ----------------------------------------------------------------------------
package rspt_pkg;

  localparam int unsigned MaxSegments = 32;
  localparam int unsigned SegW        = $clog2(MaxSegments);
  localparam int unsigned CntW        = SegW + 1;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ProdW       = 2 * CoordW;
  localparam int unsigned DistW       = ProdW + 1;
  localparam int unsigned BitCntW     = $clog2(CoordW);
  localparam int unsigned RegW        = 6;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  typedef enum logic [1:0] {
    FuncLoad   = 2'd0,
    FuncStart  = 2'd1,
    FuncUpdate = 2'd2
  } func_e;

  typedef enum logic {
    RegSegCount = 1'b0
  } reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StDiff,
    StMul,
    StSum,
    StDone
  } state_e;

endpackage

FILE: src/route_segment_progress_tracker.sv
// ----------------------------------------------------------------------------
// route_segment_progress_tracker: active route segment tracking
// Holds segment end points and advances the active segment on position
// updates while the next end point is at most as far as the active one.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | func_i, seg_index_i, coord_x_i, coord_y_i
//  out     | out_valid_o/out_ready_i | active_segment_o, progress_o, advanced_o
//  cfg     | APB psel/penable/pready | paddr, pwdata, prdata (segment_count @0)
//
//  Load, start, unused codes and updates that cannot advance go from accept
//  straight to the done state without a distance compare.
//  Updates that can advance square the distance to the active end point and
//  then to each next one, using the bit-serial 32x32 shift-add multipliers.
//  Reset clears the active index, segment_count (to 1) and the output valid.
//  A new transaction is taken while the previous result still waits.
module route_segment_progress_tracker
  import rspt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [SegW-1:0]     seg_index_i,
  input  logic [CoordW-1:0]   coord_x_i,
  input  logic [CoordW-1:0]   coord_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SegW-1:0]     active_segment_o,
  output logic [CntW-1:0]     progress_o,
  output logic                advanced_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  state_e               state_q, state_d;
  logic [RegW-1:0]      seg_count_q;
  logic [SegW-1:0]      active_q;
  logic                 adv_q;
  logic                 nxt_q;
  logic [CoordW-1:0]    pos_x_q, pos_y_q;
  logic [CoordW-1:0]    mcand_x_q, mcand_y_q;
  logic [ProdW-1:0]     prod_x_q, prod_y_q;
  logic [BitCntW-1:0]   bit_cnt_q;
  logic [DistW-1:0]     dcur_q;
  logic                 out_valid_q;
  logic [SegW-1:0]      out_act_q;
  logic                 out_adv_q;

  logic                 in_acc;
  logic                 ram_we;
  logic [SegW-1:0]      ram_raddr;
  logic [ProdW-1:0]     ram_rdata;
  logic [CoordW-1:0]    end_x, end_y;
  logic [CntW-1:0]      eff_cnt;
  logic [CntW-1:0]      act_inc;
  logic                 can_adv_now;
  logic                 can_adv_next;
  logic [DistW-1:0]     dist_sum;
  logic                 nxt_le;
  logic [CoordW-1:0]    abs_x, abs_y;
  logic [CoordW:0]      sum_x, sum_y;
  logic                 cfg_we;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[ApbAddrW-1] == RegSegCount);

  always_comb begin
    prdata = '0;
    if (paddr[ApbAddrW-1] == RegSegCount) begin
      prdata = {{(ApbDataW-RegW){1'b0}}, seg_count_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= RegW'(1);
    end else if (cfg_we) begin
      seg_count_q <= pwdata[RegW-1:0];
    end
  end

  always_comb begin
    if (seg_count_q == '0) begin
      eff_cnt = CntW'(1);
    end else if (seg_count_q > RegW'(MaxSegments)) begin
      eff_cnt = CntW'(MaxSegments);
    end else begin
      eff_cnt = CntW'(seg_count_q);
    end
  end

  assign act_inc      = {1'b0, active_q} + CntW'(1);
  assign can_adv_now  = act_inc < eff_cnt;
  assign can_adv_next = (act_inc + CntW'(1)) < eff_cnt;

  // end point table
  assign in_acc    = in_valid_i & in_ready_o;
  assign ram_we    = in_acc & (func_i == FuncLoad);
  assign ram_raddr = nxt_q ? act_inc[SegW-1:0] : active_q;

  rspt_ram #(
    .Width(ProdW),
    .Depth(MaxSegments)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(seg_index_i),
    .wdata_i({coord_x_i, coord_y_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign end_x = ram_rdata[ProdW-1:CoordW];
  assign end_y = ram_rdata[CoordW-1:0];

  // absolute coordinate differences
  always_comb begin
    if ($signed(pos_x_q) >= $signed(end_x)) begin
      abs_x = pos_x_q - end_x;
    end else begin
      abs_x = end_x - pos_x_q;
    end
    if ($signed(pos_y_q) >= $signed(end_y)) begin
      abs_y = pos_y_q - end_y;
    end else begin
      abs_y = end_y - pos_y_q;
    end
  end

  // one multiplier bit per cycle
  assign sum_x = {1'b0, prod_x_q[ProdW-1:CoordW]} + (prod_x_q[0] ? {1'b0, mcand_x_q} : '0);
  assign sum_y = {1'b0, prod_y_q[ProdW-1:CoordW]} + (prod_y_q[0] ? {1'b0, mcand_y_q} : '0);

  assign dist_sum = {1'b0, prod_x_q} + {1'b0, prod_y_q};
  assign nxt_le   = dist_sum <= dcur_q;

  // controller
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (func_i == FuncUpdate && can_adv_now) begin
            state_d = StRead;
          end else begin
            state_d = StDone;
          end
        end
      end
      StRead: state_d = StDiff;
      StDiff: state_d = StMul;
      StMul: begin
        if (bit_cnt_q == BitCntW'(CoordW - 1)) begin
          state_d = StSum;
        end
      end
      StSum: begin
        if (!nxt_q) begin
          state_d = StRead;
        end else if (nxt_le && can_adv_next) begin
          state_d = StRead;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      active_q    <= '0;
      adv_q       <= 1'b0;
      nxt_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            adv_q <= 1'b0;
            nxt_q <= 1'b0;
            if (func_i == FuncStart) begin
              active_q <= '0;
            end
          end
        end
        StSum: begin
          if (!nxt_q) begin
            nxt_q <= 1'b1;
          end else if (nxt_le) begin
            active_q <= act_inc[SegW-1:0];
            adv_q    <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          pos_x_q <= coord_x_i;
          pos_y_q <= coord_y_i;
        end
      end
      StDiff: begin
        mcand_x_q <= abs_x;
        mcand_y_q <= abs_y;
        prod_x_q  <= {{CoordW{1'b0}}, abs_x};
        prod_y_q  <= {{CoordW{1'b0}}, abs_y};
        bit_cnt_q <= '0;
      end
      StMul: begin
        prod_x_q  <= {sum_x, prod_x_q[CoordW-1:1]};
        prod_y_q  <= {sum_y, prod_y_q[CoordW-1:1]};
        bit_cnt_q <= bit_cnt_q + BitCntW'(1);
      end
      StSum: begin
        if (!nxt_q || nxt_le) begin
          dcur_q <= dist_sum;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_act_q <= active_q;
          out_adv_q <= adv_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign active_segment_o = out_act_q;
  assign progress_o       = {1'b0, out_act_q} - CntW'(1);
  assign advanced_o       = out_adv_q;

endmodule

FILE: src/rspt_ram.sv
// ----------------------------------------------------------------------------
// rspt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module rspt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rspt_checker.sv
// ----------------------------------------------------------------------------
// rspt_checker: port-level checks for the route segment progress tracker
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
module rspt_checker
  import rspt_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [SegW-1:0] active_segment_o,
  input logic [CntW-1:0] progress_o,
  input logic            advanced_o
);

  // progress always trails the active index by one
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (progress_o == ({1'b0, active_segment_o} - CntW'(1))))
    else $error("progress does not match active segment");

  // an advance never leaves segment 0 active
  a_adv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && advanced_o) |-> (active_segment_o != '0))
    else $error("advance reported at segment 0");

  // a transaction taken in one cycle cannot produce a result in the next
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |=> !out_valid_o)
    else $error("result appeared one cycle after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(active_segment_o) && $stable(advanced_o)))
    else $error("stalled result changed");

endmodule

bind route_segment_progress_tracker rspt_checker u_rspt_checker (.*);
